/* rtl/core/frh_pkg.sv */
// Shared constants for the frame harmonic rotation unit.
// Holds the inverse CORDIC gain, guard bits and the arctangent table in turn units.
// No dependencies.
package frh_pkg;

    localparam int GUARD_BITS = 4;
    localparam int GAIN_SHIFT = 30 - GUARD_BITS;
    localparam int Z_WIDTH    = 33;
    localparam int XY_MARGIN  = 6;

    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

/* rtl/core/frh_prescale.sv */
// Entry stage of one rotation lane: gain compensation and quadrant fold.
// Registers the prescaled pair and the initial CORDIC angle.
// Depends on frh_pkg.
module frh_prescale #(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                                           clk,
    input  logic                                           en,
    input  logic signed [DATA_WIDTH-1:0]                   x_in,
    input  logic signed [DATA_WIDTH-1:0]                   y_in,
    input  logic [ANGLE_WIDTH-1:0]                         phase,
    output logic signed [DATA_WIDTH+frh_pkg::XY_MARGIN-1:0] x_out,
    output logic signed [DATA_WIDTH+frh_pkg::XY_MARGIN-1:0] y_out,
    output logic signed [frh_pkg::Z_WIDTH-1:0]             z_out
);
    import frh_pkg::*;

    localparam int XW = DATA_WIDTH + XY_MARGIN;
    localparam int PW = DATA_WIDTH + 32;
    localparam logic signed [PW-1:0] ROUND = PW'(64'sd1 <<< (GAIN_SHIFT - 1));

    logic signed [PW-1:0]  prod_x;
    logic signed [PW-1:0]  prod_y;
    logic signed [XW-1:0]  pre_x;
    logic signed [XW-1:0]  pre_y;
    logic [31:0]           turn;
    logic                  fold;
    logic [31:0]           turn_fold;
    logic signed [XW-1:0]  x_next;
    logic signed [XW-1:0]  y_next;
    logic signed [Z_WIDTH-1:0] z_next;
    logic signed [XW-1:0]  x_reg;
    logic signed [XW-1:0]  y_reg;
    logic signed [Z_WIDTH-1:0] z_reg;

    assign prod_x = PW'(x_in) * PW'(GAIN_Q30) + ROUND;
    assign prod_y = PW'(y_in) * PW'(GAIN_Q30) + ROUND;
    assign pre_x  = XW'($signed(prod_x[PW-1:GAIN_SHIFT]));
    assign pre_y  = XW'($signed(prod_y[PW-1:GAIN_SHIFT]));

    assign turn      = 32'(phase) << (32 - ANGLE_WIDTH);
    assign fold      = turn[31] ^ turn[30];
    assign turn_fold = {turn[31] ^ fold, turn[30:0]};

    assign x_next = fold ? -pre_x : pre_x;
    assign y_next = fold ? -pre_y : pre_y;
    assign z_next = Z_WIDTH'($signed(turn_fold));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* rtl/core/frh_cell.sv */
// One CORDIC rotation cell with a fixed shift, registered at its output.
// Instances are chained so that each one does one iteration per cycle while enabled.
// Depends on frh_pkg.
module frh_cell #(
    parameter int XW    = 22,
    parameter int SHIFT = 0
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [XW-1:0]               x_in,
    input  logic signed [XW-1:0]               y_in,
    input  logic signed [frh_pkg::Z_WIDTH-1:0] z_in,
    output logic signed [XW-1:0]               x_out,
    output logic signed [XW-1:0]               y_out,
    output logic signed [frh_pkg::Z_WIDTH-1:0] z_out
);
    import frh_pkg::*;

    localparam logic signed [Z_WIDTH-1:0] STEP_ANGLE = Z_WIDTH'(ATAN_TURN[SHIFT]);

    logic signed [XW-1:0]      dx;
    logic signed [XW-1:0]      dy;
    logic                      pos;
    logic signed [XW-1:0]      x_next;
    logic signed [XW-1:0]      y_next;
    logic signed [Z_WIDTH-1:0] z_next;
    logic signed [XW-1:0]      x_reg;
    logic signed [XW-1:0]      y_reg;
    logic signed [Z_WIDTH-1:0] z_reg;

    assign dx  = y_in >>> SHIFT;
    assign dy  = x_in >>> SHIFT;
    assign pos = ~z_in[Z_WIDTH-1];

    assign x_next = pos ? x_in - dx : x_in + dx;
    assign y_next = pos ? y_in + dy : y_in - dy;
    assign z_next = pos ? z_in - STEP_ANGLE : z_in + STEP_ANGLE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* rtl/core/frh_finish.sv */
// Output stage of one rotation lane: drops the guard bits with rounding,
// saturates to the coefficient width and can force zero. Depends on frh_pkg.
module frh_finish #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                            clk,
    input  logic                                            en,
    input  logic                                            zero,
    input  logic signed [DATA_WIDTH+frh_pkg::XY_MARGIN-1:0] x_in,
    input  logic signed [DATA_WIDTH+frh_pkg::XY_MARGIN-1:0] y_in,
    output logic signed [DATA_WIDTH-1:0]                    x_out,
    output logic signed [DATA_WIDTH-1:0]                    y_out
);
    import frh_pkg::*;

    localparam int XW = DATA_WIDTH + XY_MARGIN;
    localparam logic signed [XW-1:0] HALF = XW'(1 << (GUARD_BITS - 1));
    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [XW-1:0]         x_rnd;
    logic signed [XW-1:0]         y_rnd;
    logic [DATA_WIDTH-1:0]        x_sat;
    logic [DATA_WIDTH-1:0]        y_sat;
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic signed [DATA_WIDTH-1:0] y_reg;

    function automatic logic [DATA_WIDTH-1:0] saturate(input logic signed [XW-1:0] v);
        logic [XW-DATA_WIDTH:0] top;
        top = v[XW-1:DATA_WIDTH-1];
        if ((&top) || !(|top))
            return v[DATA_WIDTH-1:0];
        else
            return v[XW-1] ? MIN_VAL : MAX_VAL;
    endfunction

    assign x_rnd = (x_in + HALF) >>> GUARD_BITS;
    assign y_rnd = (y_in + HALF) >>> GUARD_BITS;
    assign x_sat = zero ? '0 : saturate(x_rnd);
    assign y_sat = zero ? '0 : saturate(y_rnd);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= $signed(x_sat);
            y_reg <= $signed(y_sat);
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

/* rtl/core/frame_harmonic_rotate_unit.sv */
// Top level of the frame harmonic rotation unit.
// Instantiates two lanes of prescale, CORDIC cell chain and finish stages.
// Depends on frh_pkg, frh_prescale, frh_cell and frh_finish.
//
// The input channel (in_valid/in_ready) carries one coefficient vector
// comp0..comp4 and an angle per transaction. The output channel
// (out_valid/out_ready) returns rot0..rot4 for each input transaction, in
// order. The configuration channel (cfg_valid/cfg_ready) writes aniso_mode
// from bit 0 of cfg_data; it is always ready and should only be written
// while no transaction is in flight.
// The pipeline has one prescale stage, one cell per CORDIC iteration, and
// one rounding stage that is also the output register. Throughput is one
// transaction per cycle while the output is not stalled, set by the cell
// chain in which every cell does one iteration on both lanes each cycle.
// When the receiver stalls, the output holds and stages behind it keep
// filling empty slots, so in_ready drops only once every stage is full.
// Reset empties the pipeline and sets aniso_mode to anisotropic.
module frame_harmonic_rotate_unit #(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] comp0,
    input  logic signed [DATA_WIDTH-1:0] comp1,
    input  logic signed [DATA_WIDTH-1:0] comp2,
    input  logic signed [DATA_WIDTH-1:0] comp3,
    input  logic signed [DATA_WIDTH-1:0] comp4,
    input  logic [ANGLE_WIDTH-1:0]       angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] rot0,
    output logic signed [DATA_WIDTH-1:0] rot1,
    output logic signed [DATA_WIDTH-1:0] rot2,
    output logic signed [DATA_WIDTH-1:0] rot3,
    output logic signed [DATA_WIDTH-1:0] rot4
);
    import frh_pkg::*;

    localparam int XW = DATA_WIDTH + XY_MARGIN;
    localparam int NS = DATA_WIDTH + 2;

    logic                         aniso_mode_reg;
    logic [NS-1:0]                valid_reg;
    logic [NS:0]                  stage_rdy;
    logic [NS-1:0]                mode_reg;
    logic signed [DATA_WIDTH-1:0] c0_reg [NS];

    logic [ANGLE_WIDTH-1:0] phase_x2;
    logic [ANGLE_WIDTH-1:0] phase_x4;
    logic [ANGLE_WIDTH-1:0] phase_a;

    logic signed [XW-1:0]      xa [DATA_WIDTH+1];
    logic signed [XW-1:0]      ya [DATA_WIDTH+1];
    logic signed [Z_WIDTH-1:0] za [DATA_WIDTH+1];
    logic signed [XW-1:0]      xb [DATA_WIDTH+1];
    logic signed [XW-1:0]      yb [DATA_WIDTH+1];
    logic signed [Z_WIDTH-1:0] zb [DATA_WIDTH+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            aniso_mode_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            aniso_mode_reg <= cfg_data;
    end

    assign stage_rdy[NS] = out_ready;

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_rdy
            assign stage_rdy[s] = ~valid_reg[s] | stage_rdy[s+1];
        end
    endgenerate

    assign in_ready = stage_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (stage_rdy[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (stage_rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            c0_reg[0]   <= comp0;
            mode_reg[0] <= aniso_mode_reg;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (stage_rdy[k])
            begin
                c0_reg[k]   <= c0_reg[k-1];
                mode_reg[k] <= mode_reg[k-1];
            end
        end
    end

    assign phase_x2 = {angle[ANGLE_WIDTH-2:0], 1'b0};
    assign phase_x4 = {angle[ANGLE_WIDTH-3:0], 2'b00};
    assign phase_a  = aniso_mode_reg ? phase_x2 : phase_x4;

    frh_prescale #(
        .DATA_WIDTH  (DATA_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_pre_a (
        .clk   (clk),
        .en    (stage_rdy[0]),
        .x_in  (comp1),
        .y_in  (comp2),
        .phase (phase_a),
        .x_out (xa[0]),
        .y_out (ya[0]),
        .z_out (za[0])
    );

    frh_prescale #(
        .DATA_WIDTH  (DATA_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_pre_b (
        .clk   (clk),
        .en    (stage_rdy[0]),
        .x_in  (comp3),
        .y_in  (comp4),
        .phase (phase_x4),
        .x_out (xb[0]),
        .y_out (yb[0]),
        .z_out (zb[0])
    );

    genvar i;
    generate
        for (i = 0; i < DATA_WIDTH; i++)
        begin : g_cell
            frh_cell #(
                .XW    (XW),
                .SHIFT (i)
            ) u_cell_a (
                .clk   (clk),
                .en    (stage_rdy[i+1]),
                .x_in  (xa[i]),
                .y_in  (ya[i]),
                .z_in  (za[i]),
                .x_out (xa[i+1]),
                .y_out (ya[i+1]),
                .z_out (za[i+1])
            );

            frh_cell #(
                .XW    (XW),
                .SHIFT (i)
            ) u_cell_b (
                .clk   (clk),
                .en    (stage_rdy[i+1]),
                .x_in  (xb[i]),
                .y_in  (yb[i]),
                .z_in  (zb[i]),
                .x_out (xb[i+1]),
                .y_out (yb[i+1]),
                .z_out (zb[i+1])
            );
        end
    endgenerate

    frh_finish #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fin_a (
        .clk   (clk),
        .en    (stage_rdy[NS-1]),
        .zero  (1'b0),
        .x_in  (xa[DATA_WIDTH]),
        .y_in  (ya[DATA_WIDTH]),
        .x_out (rot1),
        .y_out (rot2)
    );

    frh_finish #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fin_b (
        .clk   (clk),
        .en    (stage_rdy[NS-1]),
        .zero  (~mode_reg[NS-2]),
        .x_in  (xb[DATA_WIDTH]),
        .y_in  (yb[DATA_WIDTH]),
        .x_out (rot3),
        .y_out (rot4)
    );

    assign out_valid = valid_reg[NS-1];
    assign rot0      = c0_reg[NS-1];

endmodule

/* rtl/core/frh_checker.sv */
// Port-level checks for the frame harmonic rotation unit.
// Attached to frame_harmonic_rotate_unit by the bind statement below.
// No package dependencies.
module frh_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] rot0,
    input logic signed [DATA_WIDTH-1:0] rot1,
    input logic signed [DATA_WIDTH-1:0] rot2
);

    // A stalled output transaction stays valid and keeps rot0..rot2 stable.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rot0) && $stable(rot1)
            && $stable(rot2))
        else $error("output transaction changed while stalled");

    // With the receiver ready, nothing in the pipeline can block the input.
    a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while receiver ready");

    // An empty output register leaves room for every stage to advance.
    a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output register empty");

endmodule

bind frame_harmonic_rotate_unit frh_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_frh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rot0      (rot0),
    .rot1      (rot1),
    .rot2      (rot2)
);

/* tb/tb.sv */
// Self-checking testbench for frame_harmonic_rotate_unit with valid/ready traffic on all channels.
// Predicts untyped rotations with its own bit-exact CORDIC model; compares results in order.
// Depends only on the RTL of frame_harmonic_rotate_unit.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LATENCY         = 18;
    localparam int     CYCLE_LIMIT     = 300000;
    localparam int     PHASES          = 6;
    localparam int     ITEMS_PER_PHASE = 200;
    localparam longint INV_GAIN_Q30    = 652032874;

    localparam longint TURN_ATAN [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    localparam logic [15:0] EDGE_ANGLES [8] = '{
        16'h0000, 16'h1FFF, 16'h2000, 16'h3FFF,
        16'h4000, 16'h8000, 16'hC000, 16'hFFFF
    };

    localparam bit PHASE_MODE [PHASES]      = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam int PHASE_SEND_IDLE [PHASES] = '{0, 51, 0, 32, 0, 32};
    localparam int PHASE_STALL [PHASES]     = '{0, 0, 51, 32, 0, 32};

    typedef logic [4:0][15:0] coef_vec_t;

    typedef struct packed {
        coef_vec_t   comp;
        logic [15:0] angle;
    } frame_t;

    typedef struct {
        bit mode;
        bit typed;
        int c0, c1, c2, c3, c4;
        int ang;
        int e0, e1, e2, e3, e4;
    } vector_row_t;

    // Columns: mode, typed, comp0..comp4, angle, rot0..rot4 (used only when typed).
    vector_row_t directed_rows [23] = '{
        '{1'b1, 1'b1, 0, 0, 0, 0, 0, 'h0000, 0, 0, 0, 0, 0},
        '{1'b1, 1'b1, 32767, 0, 0, 0, 0, 'hFFFF, 32767, 0, 0, 0, 0},
        '{1'b1, 1'b1, -32768, 0, 0, 0, 0, 12345, -32768, 0, 0, 0, 0},
        '{1'b1, 1'b0, 32767, 32767, 32767, 32767, 32767, 'h0000, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, -32768, -32768, -32768, -32768, -32768, 'h0000, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, 100, 8192, 0, 8192, 0, 'h4000, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, -1, 8192, -8192, -8192, 8192, 'h2000, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, 0, 32767, 32767, 32767, 32767, 'hF000, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, 0, -32768, -32768, -32768, -32768, 'h1000, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, 5, 32767, -32768, -32768, 32767, 'h8000, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, 0, 1, -1, 1, -1, 'hFFFF, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, 0, 12000, -7000, 3000, 25000, 'h3FFF, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, 0, 12000, -7000, 3000, 25000, 'hC000, 0, 0, 0, 0, 0},
        '{1'b0, 1'b1, 0, 0, 0, 0, 0, 'h0000, 0, 0, 0, 0, 0},
        '{1'b0, 1'b1, 32767, 0, 0, 32767, -32768, 'h4000, 32767, 0, 0, 0, 0},
        '{1'b0, 1'b1, -32768, 0, 0, -32768, 32767, 'hFFFF, -32768, 0, 0, 0, 0},
        '{1'b0, 1'b0, 0, 32767, 32767, 0, 0, 'h2000, 0, 0, 0, 0, 0},
        '{1'b0, 1'b0, 0, 32767, 32767, 1234, -1234, 'h0800, 0, 0, 0, 0, 0},
        '{1'b0, 1'b0, 7, -32768, 32767, 32767, -32768, 'h4000, 0, 0, 0, 0, 0},
        '{1'b0, 1'b0, 0, 8192, 4096, 0, 0, 'h1000, 0, 0, 0, 0, 0},
        '{1'b0, 1'b0, 0, -5000, 20000, 0, 0, 'hFFFF, 0, 0, 0, 0, 0},
        '{1'b1, 1'b0, 1, 2, 3, 4, 5, 'h5555, 0, 0, 0, 0, 0},
        '{1'b1, 1'b1, 0, 0, 0, 0, 0, 'h4000, 0, 0, 0, 0, 0}
    };

    string rot_name [5] = '{"rot0", "rot1", "rot2", "rot3", "rot4"};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [15:0] comp0     = '0;
    logic [15:0] comp1     = '0;
    logic [15:0] comp2     = '0;
    logic [15:0] comp3     = '0;
    logic [15:0] comp4     = '0;
    logic [15:0] angle     = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] rot0;
    logic [15:0] rot1;
    logic [15:0] rot2;
    logic [15:0] rot3;
    logic [15:0] rot4;

    coef_vec_t pending_rots [$];
    bit        aniso_shadow  = 1'b1;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        hold_cycles   = 0;
    int        fault_count   = 0;
    int        cycle_count   = 0;

    frame_harmonic_rotate_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .comp0     (comp0),
        .comp1     (comp1),
        .comp2     (comp2),
        .comp3     (comp3),
        .comp4     (comp4),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rot0      (rot0),
        .rot1      (rot1),
        .rot2      (rot2),
        .rot3      (rot3),
        .rot4      (rot4)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [15:0] round_saturate(input longint v);
        longint r;
        r = (v + 8) >>> 4;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic void rotate_pair(input longint xi, input longint yi,
                                        input logic [15:0] turn,
                                        output logic [15:0] xo, output logic [15:0] yo);
        logic [31:0] phase;
        longint      x, y, z, dx, dy;
        phase = {turn, 16'h0000};
        x = (xi * INV_GAIN_Q30 + 64'sd33554432) >>> 26;
        y = (yi * INV_GAIN_Q30 + 64'sd33554432) >>> 26;
        if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10)
        begin
            x = -x;
            y = -y;
            phase = phase + 32'h8000_0000;
        end
        z = $signed(phase);
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= TURN_ATAN[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += TURN_ATAN[i];
            end
        end
        xo = round_saturate(x);
        yo = round_saturate(y);
    endfunction

    function automatic coef_vec_t predict_rotation(input frame_t f, input bit aniso);
        coef_vec_t   r;
        logic [15:0] twice, quad;
        twice = f.angle << 1;
        quad  = f.angle << 2;
        r = '0;
        r[0] = f.comp[0];
        if (aniso)
        begin
            rotate_pair($signed(f.comp[1]), $signed(f.comp[2]), twice, r[1], r[2]);
            rotate_pair($signed(f.comp[3]), $signed(f.comp[4]), quad, r[3], r[4]);
        end
        else
        begin
            rotate_pair($signed(f.comp[1]), $signed(f.comp[2]), quad, r[1], r[2]);
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        for (int k = 0; k < 5; k++)
            f.comp[k] = pick_coef();
        if ($urandom_range(7) == 0)
            f.angle = EDGE_ANGLES[$urandom_range(7)];
        else
            f.angle = 16'($urandom);
        return f;
    endfunction

    task automatic send_frame(input frame_t f, input bit typed, input coef_vec_t typed_rot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        comp0    <= f.comp[0];
        comp1    <= f.comp[1];
        comp2    <= f.comp[2];
        comp3    <= f.comp[3];
        comp4    <= f.comp[4];
        angle    <= f.angle;
        do
            @(posedge clk);
        while (!in_ready);
        pending_rots.push_back(typed ? typed_rot : predict_rotation(f, aniso_shadow));
    endtask

    task automatic wait_for_drain();
        while (pending_rots.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input bit mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        aniso_shadow = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_rotation(input coef_vec_t got);
        coef_vec_t want;
        if (pending_rots.size() == 0)
        begin
            $error("rotation result arrived with no pending transaction");
            fault_count++;
        end
        else
        begin
            want = pending_rots.pop_front();
            for (int k = 0; k < 5; k++)
            begin
                if (got[k] !== want[k])
                begin
                    $error("%s mismatch: expected %0d, got %0d",
                           rot_name[k], $signed(want[k]), $signed(got[k]));
                    fault_count++;
                end
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_rotation({rot4, rot3, rot2, rot1, rot0});
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        vector_row_t row;
        frame_t      f;
        coef_vec_t   typed_rot;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            if (row.mode != aniso_shadow)
            begin
                in_valid <= 1'b0;
                wait_for_drain();
                write_mode(row.mode);
            end
            f.comp    = {16'(row.c4), 16'(row.c3), 16'(row.c2), 16'(row.c1), 16'(row.c0)};
            f.angle   = 16'(row.ang);
            typed_rot = {16'(row.e4), 16'(row.e3), 16'(row.e2), 16'(row.e1), 16'(row.e0)};
            send_frame(f, row.typed, typed_rot);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            wait_for_drain();
            write_mode(PHASE_MODE[p]);
            send_idle_pct = PHASE_SEND_IDLE[p];
            stall_pct     = PHASE_STALL[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ((p == 0 || p == 4) && n == 50)
                    hold_cycles = 120;
                if (p == 3 && n == 100)
                begin
                    in_valid <= 1'b0;
                    wait_for_drain();
                end
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        wait_for_drain();
        repeat (LATENCY + 4) @(posedge clk);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
